[rtl/core/dbf_pkg.sv]
// Package: shared types, register indexes and lookup tables for the deblocking line filter.
package dbf_pkg;

    localparam int unsigned QpMax = 51;

    typedef enum logic [0:0] {
        REG_ALPHA_OFFSET = 1'b0,
        REG_BETA_OFFSET  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] p3_in;
        logic [7:0] p2_in;
        logic [7:0] p1_in;
        logic [7:0] p0_in;
        logic [7:0] q0_in;
        logic [7:0] q1_in;
        logic [7:0] q2_in;
        logic [7:0] q3_in;
        logic [2:0] edge_strength;
        logic [5:0] qp_p;
        logic [5:0] qp_q;
        logic       is_chroma;
    } line_in_t;

    typedef struct packed {
        logic [7:0] p2_out;
        logic [7:0] p1_out;
        logic [7:0] p0_out;
        logic [7:0] q0_out;
        logic [7:0] q1_out;
        logic [7:0] q2_out;
        logic       was_filtered;
    } line_out_t;

    // Thresholds looked up for one line.
    typedef struct packed {
        logic [7:0] alpha;
        logic [4:0] beta;
        logic [4:0] tc0;
    } thr_t;

    function automatic logic [7:0] alpha_lut(input logic [5:0] idx);
        logic [7:0] r;
        unique case (idx)
            6'd16, 6'd17: r = 8'd4;
            6'd18: r = 8'd5;    6'd19: r = 8'd6;    6'd20: r = 8'd7;
            6'd21: r = 8'd8;    6'd22: r = 8'd9;    6'd23: r = 8'd10;
            6'd24: r = 8'd12;   6'd25: r = 8'd13;   6'd26: r = 8'd15;
            6'd27: r = 8'd17;   6'd28: r = 8'd20;   6'd29: r = 8'd22;
            6'd30: r = 8'd25;   6'd31: r = 8'd28;   6'd32: r = 8'd32;
            6'd33: r = 8'd36;   6'd34: r = 8'd40;   6'd35: r = 8'd45;
            6'd36: r = 8'd50;   6'd37: r = 8'd56;   6'd38: r = 8'd63;
            6'd39: r = 8'd71;   6'd40: r = 8'd80;   6'd41: r = 8'd90;
            6'd42: r = 8'd101;  6'd43: r = 8'd113;  6'd44: r = 8'd127;
            6'd45: r = 8'd144;  6'd46: r = 8'd162;  6'd47: r = 8'd182;
            6'd48: r = 8'd203;  6'd49: r = 8'd226;
            6'd50, 6'd51: r = 8'd255;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] beta_lut(input logic [5:0] idx);
        logic [4:0] r;
        unique case (idx)
            6'd16, 6'd17, 6'd18: r = 5'd2;
            6'd19, 6'd20, 6'd21, 6'd22: r = 5'd3;
            6'd23, 6'd24, 6'd25: r = 5'd4;
            6'd26, 6'd27: r = 5'd6;
            6'd28, 6'd29: r = 5'd7;
            6'd30, 6'd31: r = 5'd8;
            6'd32, 6'd33: r = 5'd9;
            6'd34, 6'd35: r = 5'd10;
            6'd36, 6'd37: r = 5'd11;
            6'd38, 6'd39: r = 5'd12;
            6'd40, 6'd41: r = 5'd13;
            6'd42, 6'd43: r = 5'd14;
            6'd44, 6'd45: r = 5'd15;
            6'd46, 6'd47: r = 5'd16;
            6'd48, 6'd49: r = 5'd17;
            6'd50, 6'd51: r = 5'd18;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Packed row {bs3, bs2, bs1}.
    function automatic logic [14:0] tc0_row(input logic [5:0] idx);
        logic [14:0] r;
        unique case (idx)
            6'd17, 6'd18, 6'd19, 6'd20: r = {5'd1, 5'd0, 5'd0};
            6'd21, 6'd22: r = {5'd1, 5'd1, 5'd0};
            6'd23, 6'd24, 6'd25, 6'd26: r = {5'd1, 5'd1, 5'd1};
            6'd27, 6'd28, 6'd29, 6'd30: r = {5'd2, 5'd1, 5'd1};
            6'd31, 6'd32: r = {5'd3, 5'd2, 5'd1};
            6'd33: r = {5'd3, 5'd2, 5'd2};
            6'd34: r = {5'd4, 5'd2, 5'd2};
            6'd35, 6'd36: r = {5'd4, 5'd3, 5'd2};
            6'd37: r = {5'd5, 5'd3, 5'd3};
            6'd38, 6'd39: r = {5'd6, 5'd4, 5'd3};
            6'd40: r = {5'd7, 5'd5, 5'd4};
            6'd41: r = {5'd8, 5'd5, 5'd4};
            6'd42: r = {5'd9, 5'd6, 5'd4};
            6'd43: r = {5'd10, 5'd7, 5'd5};
            6'd44: r = {5'd11, 5'd8, 5'd6};
            6'd45: r = {5'd13, 5'd8, 5'd6};
            6'd46: r = {5'd14, 5'd10, 5'd7};
            6'd47: r = {5'd16, 5'd11, 5'd8};
            6'd48: r = {5'd18, 5'd12, 5'd9};
            6'd49: r = {5'd20, 5'd13, 5'd10};
            6'd50: r = {5'd23, 5'd15, 5'd11};
            6'd51: r = {5'd25, 5'd17, 5'd13};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/dbf_if.sv]
// Interfaces: line request channel, result channel and configuration write channel.
interface dbf_line_if;
    logic                valid;
    logic                ready;
    dbf_pkg::line_in_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbf_result_if;
    logic                valid;
    logic                ready;
    dbf_pkg::line_out_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbf_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [4:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/dbf_thresh.sv]
// Threshold lookup: averaged QP plus offsets, clamp, alpha/beta/tc0 tables.
module dbf_thresh (
    input  logic [5:0]        qp_p,
    input  logic [5:0]        qp_q,
    input  logic [2:0]        bs,
    input  logic [4:0]        alpha_offset,
    input  logic [4:0]        beta_offset,
    output dbf_pkg::thr_t     thr
);
    logic [5:0]        qav;
    logic signed [7:0] ia_raw;
    logic signed [7:0] ib_raw;
    logic [5:0]        ia;
    logic [5:0]        ib;
    logic [14:0]       row;

    function automatic logic [5:0] clamp_qp(input logic signed [7:0] v);
        logic [5:0] r;
        if (v < 0)
            r = '0;
        else if (v > 8'sd51)
            r = 6'(dbf_pkg::QpMax);
        else
            r = v[5:0];
        return r;
    endfunction

    always_comb
    begin
        qav    = 6'((7'(qp_p) + 7'(qp_q) + 7'd1) >> 1);
        ia_raw = $signed({2'b00, qav}) + 8'(signed'(alpha_offset));
        ib_raw = $signed({2'b00, qav}) + 8'(signed'(beta_offset));
        ia     = clamp_qp(ia_raw);
        ib     = clamp_qp(ib_raw);
        row    = dbf_pkg::tc0_row(ia);
        thr.alpha = dbf_pkg::alpha_lut(ia);
        thr.beta  = dbf_pkg::beta_lut(ib);
        unique case (bs)
            3'd2:    thr.tc0 = row[9:5];
            3'd3:    thr.tc0 = row[14:10];
            default: thr.tc0 = row[4:0];
        endcase
    end
endmodule

[rtl/core/dbf_filter.sv]
// Sample datapath: gate, normal and strong filters for one line.
module dbf_filter (
    input  dbf_pkg::line_in_t  line,
    input  dbf_pkg::thr_t      thr,
    output dbf_pkg::line_out_t res
);
    typedef logic signed [11:0] s12_t;

    s12_t p3, p2, p1, p0, q0, q1, q2, q3;
    s12_t alpha, beta, tc0, tc, d, avg, ap, aq, apq, dp, dq;
    logic [2:0] bs;
    logic gate, strong_sel;

    function automatic s12_t absd(input s12_t a, input s12_t b);
        s12_t x;
        x = a - b;
        return (x < 0) ? -x : x;
    endfunction

    function automatic s12_t clip(input s12_t lo, input s12_t hi, input s12_t x);
        s12_t r;
        if (x < lo)
            r = lo;
        else if (x > hi)
            r = hi;
        else
            r = x;
        return r;
    endfunction

    always_comb
    begin
        p3 = s12_t'(line.p3_in); p2 = s12_t'(line.p2_in);
        p1 = s12_t'(line.p1_in); p0 = s12_t'(line.p0_in);
        q0 = s12_t'(line.q0_in); q1 = s12_t'(line.q1_in);
        q2 = s12_t'(line.q2_in); q3 = s12_t'(line.q3_in);
        bs = (line.edge_strength > 3'd4) ? 3'd4 : line.edge_strength;
        alpha = s12_t'(thr.alpha);
        beta  = s12_t'(thr.beta);
        tc0   = s12_t'(thr.tc0);
        apq = absd(p0, q0);
        ap  = absd(p2, p0);
        aq  = absd(q2, q0);
        gate = (bs != 3'd0) && (alpha != 0) && (beta != 0) && (apq < alpha)
            && (absd(p1, p0) < beta) && (absd(q1, q0) < beta);
        strong_sel = !line.is_chroma && (apq < ((alpha >>> 2) + 12'sd2));
        avg = (p0 + q0 + 12'sd1) >>> 1;
        dp  = clip(-tc0, tc0, (p2 + avg - (p1 <<< 1)) >>> 1);
        dq  = clip(-tc0, tc0, (q2 + avg - (q1 <<< 1)) >>> 1);

        res.p2_out = line.p2_in; res.p1_out = line.p1_in;
        res.p0_out = line.p0_in; res.q0_out = line.q0_in;
        res.q1_out = line.q1_in; res.q2_out = line.q2_in;
        res.was_filtered = gate;
        tc = tc0;
        d  = '0;

        if (gate && bs != 3'd4) begin
            if (line.is_chroma) begin
                tc = tc0 + 12'sd1;
            end else begin
                if (ap < beta) begin
                    res.p1_out = 8'(p1 + dp);
                    tc = tc + 12'sd1;
                end
                if (aq < beta) begin
                    res.q1_out = 8'(q1 + dq);
                    tc = tc + 12'sd1;
                end
            end
            d = clip(-tc, tc, (((q0 - p0) <<< 2) + (p1 - q1) + 12'sd4) >>> 3);
            res.p0_out = 8'(clip(12'sd0, 12'sd255, p0 + d));
            res.q0_out = 8'(clip(12'sd0, 12'sd255, q0 - d));
        end else if (gate) begin
            if (strong_sel && ap < beta) begin
                res.p0_out = 8'((p2 + (p1 <<< 1) + (p0 <<< 1) + (q0 <<< 1) + q1 + 12'sd4) >>> 3);
                res.p1_out = 8'((p2 + p1 + p0 + q0 + 12'sd2) >>> 2);
                res.p2_out = 8'(((p3 <<< 1) + 12'sd3 * p2 + p1 + p0 + q0 + 12'sd4) >>> 3);
            end else begin
                res.p0_out = 8'(((p1 <<< 1) + p0 + q1 + 12'sd2) >>> 2);
            end
            if (strong_sel && aq < beta) begin
                res.q0_out = 8'((p1 + (p0 <<< 1) + (q0 <<< 1) + (q1 <<< 1) + q2 + 12'sd4) >>> 3);
                res.q1_out = 8'((p0 + q0 + q1 + q2 + 12'sd2) >>> 2);
                res.q2_out = 8'(((q3 <<< 1) + 12'sd3 * q2 + q1 + q0 + p0 + 12'sd4) >>> 3);
            end else begin
                res.q0_out = 8'(((q1 <<< 1) + q0 + p1 + 12'sd2) >>> 2);
            end
        end
    end
endmodule

[rtl/core/deblock_edge_line_filter.sv]
// Top level of the deblocking edge line filter.
// Usage:
//   line_in  : one request per line, the eight samples p3..q3, boundary
//              strength, both QPs and the chroma flag.
//   result   : the filtered p2..q2 and a flag telling if the filter acted.
//   cfg      : register writes; index 0 alpha offset, index 1 beta offset,
//              5-bit two's complement. Write only while no request is open.
// Path: a request accepted on line_in goes into the input register, then
//   through lookup and filter logic into the result register.
// Throughput: one line per cycle while result is taken, set by the single
//   pass of lookup and filter between the two registers.
// Reset: both offsets clear to zero and the pipeline empties.
// Stall: when result is not taken, the result register holds; the input
//   register still takes one more request, then line_in ready drops until
//   the result drains.
module deblock_edge_line_filter (
    input  logic      clk,
    input  logic      rst_n,
    dbf_line_if.sink     line_in,
    dbf_result_if.source result,
    dbf_cfg_if.sink      cfg
);
    logic [4:0]         alpha_offset_reg;
    logic [4:0]         beta_offset_reg;
    logic               in_valid_reg;
    dbf_pkg::line_in_t  in_data_reg;
    logic               out_valid_reg;
    dbf_pkg::line_out_t out_data_reg;
    dbf_pkg::thr_t      thr;
    dbf_pkg::line_out_t res;
    logic               advance;

    assign cfg.ready = 1'b1;

    // Move the input stage forward when the result slot is free or leaving.
    assign advance       = !out_valid_reg || result.ready;
    assign line_in.ready = !in_valid_reg || advance;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_data_reg;

    dbf_thresh u_thresh (
        .qp_p         (in_data_reg.qp_p),
        .qp_q         (in_data_reg.qp_q),
        .bs           (in_data_reg.edge_strength),
        .alpha_offset (alpha_offset_reg),
        .beta_offset  (beta_offset_reg),
        .thr          (thr)
    );

    dbf_filter u_filter (
        .line (in_data_reg),
        .thr  (thr),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            alpha_offset_reg <= '0;
            beta_offset_reg  <= '0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg.valid) begin
                unique case (dbf_pkg::cfg_reg_t'(cfg.index))
                    dbf_pkg::REG_ALPHA_OFFSET: alpha_offset_reg <= cfg.wdata;
                    dbf_pkg::REG_BETA_OFFSET:  beta_offset_reg  <= cfg.wdata;
                    default: ;
                endcase
            end
            if (line_in.ready)
                in_valid_reg <= line_in.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_in.valid && line_in.ready)
            in_data_reg <= line_in.data;
        if (advance && in_valid_reg)
            out_data_reg <= res;
    end
endmodule

[rtl/core/dbf_checker.sv]
// Port checker for the deblocking line filter, bound to the top level.
module dbf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input dbf_pkg::line_in_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input dbf_pkg::line_out_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed under stall");

    // Once the result slot is free or leaving, the request shows on the next cycle.
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 (!out_valid || out_ready) |=> out_valid)
        else $error("request not shown once the result slot freed");

    a_zero_bs: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.edge_strength == 3'd0
        ##1 (!out_valid || out_ready)
        |=> !out_data.was_filtered && out_data.p0_out == $past(in_data.p0_in, 2)
            && out_data.q0_out == $past(in_data.q0_in, 2))
        else $error("zero strength line was changed");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result");
endmodule

bind deblock_edge_line_filter dbf_checker u_dbf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (line_in.valid),
    .in_ready  (line_in.ready),
    .in_data   (line_in.data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
